// File: src/stdp_pkg.sv
`timescale 1ns / 1ps
// stdp_pkg: shared types, constants and helpers for the stdp weight update block
// used by stdp_region, stdp_scale and stdp_weight_update; no dependencies

package stdp_pkg;

    localparam int REGIONS_PER_SIDE = 3;
    localparam int REGION_W         = 12;
    localparam int BANK_W           = REGIONS_PER_SIDE * REGION_W;
    localparam int EDGE_W           = 32;
    localparam int DATA_W           = 16;
    localparam int FLAG_W           = 5;
    localparam int CTRL_W           = 5;
    localparam int CFG_DATA_W       = BANK_W;
    localparam int CFG_INDEX_W      = 3;
    localparam int EXP_W            = 6;
    localparam int DELTA_W          = 48;
    localparam int SUM_W            = DELTA_W + 1;

    localparam logic signed [EXP_W-1:0] NO_REGION_EXP = -6'sd16;
    localparam logic [CTRL_W-1:0] WEIGHT_BITS_RESET   = 5'd8;

    // mode flag bit positions
    localparam int FLAG_PLASTIC = 0;
    localparam int FLAG_STDP    = 1;
    localparam int FLAG_EXPO    = 2;
    localparam int FLAG_RROUND  = 3;
    localparam int FLAG_LIMIT   = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CAUSAL_EDGES    = 3'd0,
        CFG_ACAUSAL_EDGES   = 3'd1,
        CFG_WINDOW_LENGTH   = 3'd2,
        CFG_CAUSAL_REGIONS  = 3'd3,
        CFG_ACAUSAL_REGIONS = 3'd4,
        CFG_MODE_FLAGS      = 3'd5,
        CFG_ROUNDING_BITS   = 3'd6,
        CFG_WEIGHT_BITS     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIGN_ZERO  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_NONE  = 2'd2,
        SIGN_MINUS = 2'd3
    } sign_code_t;

    typedef struct packed {
        logic [EDGE_W-1:0] causal_edges;
        logic [EDGE_W-1:0] acausal_edges;
        logic [DATA_W-1:0] window_length;
        logic [BANK_W-1:0] causal_regions;
        logic [BANK_W-1:0] acausal_regions;
        logic [FLAG_W-1:0] mode_flags;
        logic [CTRL_W-1:0] rounding_bits;
        logic [CTRL_W-1:0] weight_bits;
    } cfg_t;

    // control handed from region select to the scaling datapath
    typedef struct packed {
        logic                    apply;
        logic                    zero;
        logic                    neg;
        logic signed [EXP_W-1:0] expo;
    } scale_ctl_t;

    function automatic logic [REGION_W-1:0] region_entry(
        input logic [BANK_W-1:0] bank,
        input int                idx
    );
        region_entry = bank[REGION_W*idx +: REGION_W];
    endfunction

endpackage

// File: src/stdp_region.sv
`timescale 1ns / 1ps
// stdp_region: learning window region select and gain exponent computation
// depends on stdp_pkg

module stdp_region (
    input  stdp_pkg::cfg_t        cfg,
    input  logic                  cmd,
    input  logic signed [15:0]    time_diff,
    input  logic                  gate_pass,
    output stdp_pkg::scale_ctl_t  ctl
);
    import stdp_pkg::*;

    logic signed [16:0]       dt_x;
    logic signed [16:0]       c0_x;
    logic signed [16:0]       c1_x;
    logic signed [16:0]       len_x;
    logic signed [16:0]       nlen_x;
    logic signed [15:0]       a0;
    logic signed [15:0]       a1;
    logic [REGION_W-1:0]      entry;
    logic                     hit;
    logic signed [4:0]        e5;
    logic [1:0]               code;
    logic [4:0]               decay;
    logic signed [15:0]       dt_sh;
    logic signed [16:0]       e_diff;
    logic signed [EXP_W-1:0]  e_sat;
    logic signed [EXP_W-1:0]  e_reg;
    logic                     stdp_on;
    logic                     dt_pos;

    assign dt_x    = {time_diff[15], time_diff};
    assign c0_x    = {1'b0, cfg.causal_edges[15:0]};
    assign c1_x    = {1'b0, cfg.causal_edges[31:16]};
    assign len_x   = {1'b0, cfg.window_length};
    assign nlen_x  = -len_x;
    assign a0      = cfg.acausal_edges[15:0];
    assign a1      = cfg.acausal_edges[31:16];
    assign stdp_on = cfg.mode_flags[FLAG_STDP];
    assign dt_pos  = (dt_x > 17'sd0);

    // first matching region wins
    always_comb
    begin
        hit   = 1'b1;
        entry = '0;
        if (dt_pos && dt_x < c0_x)
            entry = region_entry(cfg.causal_regions, 0);
        else if (dt_x >= c0_x && dt_x < c1_x)
            entry = region_entry(cfg.causal_regions, 1);
        else if (dt_x >= c1_x && dt_x < len_x)
            entry = region_entry(cfg.causal_regions, 2);
        else if (time_diff < 16'sd0 && time_diff > a0)
            entry = region_entry(cfg.acausal_regions, 0);
        else if (time_diff <= a0 && time_diff > a1)
            entry = region_entry(cfg.acausal_regions, 1);
        else if (time_diff <= a1 && dt_x > nlen_x)
            entry = region_entry(cfg.acausal_regions, 2);
        else
            hit = 1'b0;
    end

    assign e5    = hit ? signed'(entry[4:0]) : NO_REGION_EXP[4:0];
    assign code  = hit ? entry[6:5] : SIGN_ZERO;
    assign decay = hit ? entry[11:7] : 5'd0;

    // floor division by 2^decay is an arithmetic shift
    assign dt_sh  = time_diff >>> decay;
    assign e_diff = {{12{e5[4]}}, e5} - {dt_sh[15], dt_sh};

    always_comb
    begin
        if (e_diff > 17'sd31)
            e_sat = 6'sd31;
        else if (e_diff < -17'sd31)
            e_sat = -6'sd31;
        else
            e_sat = e_diff[EXP_W-1:0];
    end

    assign e_reg = cfg.mode_flags[FLAG_EXPO] ? e_sat : {e5[4], e5};

    always_comb
    begin
        ctl.apply = cfg.mode_flags[FLAG_PLASTIC] && gate_pass && (cmd || (stdp_on && dt_pos));
        if (stdp_on)
        begin
            ctl.expo = e_reg;
            case (code)
                SIGN_PLUS:
                begin
                    ctl.zero = 1'b0;
                    ctl.neg  = 1'b0;
                end
                SIGN_MINUS:
                begin
                    ctl.zero = 1'b0;
                    ctl.neg  = 1'b1;
                end
                default:
                begin
                    ctl.zero = 1'b1;
                    ctl.neg  = 1'b0;
                end
            endcase
        end
        else
        begin
            // plain acausal update: first acausal gain, positive, no decay
            ctl.expo = {cfg.acausal_regions[4], cfg.acausal_regions[4:0]};
            ctl.zero = 1'b0;
            ctl.neg  = 1'b0;
        end
    end

endmodule

// File: src/stdp_scale.sv
`timescale 1ns / 1ps
// stdp_scale: power-of-two modulator scaling, randomized rounding, weight add and clamp
// depends on stdp_pkg

module stdp_scale (
    input  stdp_pkg::cfg_t        cfg,
    input  stdp_pkg::scale_ctl_t  ctl,
    input  logic signed [15:0]    modulator,
    input  logic signed [15:0]    weight,
    input  logic [15:0]           rand_bits,
    output logic signed [15:0]    new_weight,
    output logic                  updated
);
    import stdp_pkg::*;

    logic signed [DELTA_W-1:0] mod_x;
    logic signed [DELTA_W-1:0] up_val;
    logic signed [DELTA_W-1:0] dn_val;
    logic signed [DELTA_W-1:0] scaled;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] rdelta;
    logic [15:0]               mag;
    logic [15:0]               mag_sh;
    logic [EXP_W-1:0]          nexp;
    logic [30:0]               mask;
    logic [30:0]               low;
    logic [30:0]               rnd_m;
    logic                      inc;
    logic signed [SUM_W-1:0]   sum;
    logic [CTRL_W-1:0]         bc;
    logic signed [SUM_W-1:0]   lim;
    logic signed [SUM_W-1:0]   hi;
    logic signed [SUM_W-1:0]   lo;
    logic signed [SUM_W-1:0]   clamped;
    logic signed [15:0]        sat;

    assign mod_x  = {{(DELTA_W-16){modulator[15]}}, modulator};
    assign up_val = mod_x <<< ctl.expo[4:0];

    // negative exponent truncates the magnitude toward zero
    assign mag    = modulator[15] ? 16'(-modulator) : modulator;
    assign nexp   = 6'(-ctl.expo);
    assign mag_sh = mag >> nexp[4:0];
    assign dn_val = modulator[15] ? -{{(DELTA_W-16){1'b0}}, mag_sh}
                                  : {{(DELTA_W-16){1'b0}}, mag_sh};

    assign scaled = ctl.expo[EXP_W-1] ? dn_val : up_val;

    always_comb
    begin
        if (ctl.zero)
            delta = '0;
        else if (ctl.neg)
            delta = -scaled;
        else
            delta = scaled;
    end

    // randomized rounding: round up when the random draw is below the dropped bits
    assign mask   = ~(31'h7FFF_FFFF << cfg.rounding_bits);
    assign low    = delta[30:0] & mask;
    assign rnd_m  = {15'd0, rand_bits} & mask;
    assign inc    = (rnd_m < low);
    assign rdelta = cfg.mode_flags[FLAG_RROUND]
                  ? (delta >>> cfg.rounding_bits) + $signed({{(DELTA_W-1){1'b0}}, inc})
                  : delta;

    assign sum = {{(SUM_W-16){weight[15]}}, weight} + {rdelta[DELTA_W-1], rdelta};

    always_comb
    begin
        if (cfg.weight_bits == 5'd0)
            bc = 5'd1;
        else if (cfg.weight_bits > 5'd16)
            bc = 5'd16;
        else
            bc = cfg.weight_bits;
    end

    assign lim = SUM_W'(1) <<< (bc - 5'd1);
    assign hi  = lim - SUM_W'(1);
    assign lo  = -lim;

    always_comb
    begin
        clamped = sum;
        if (cfg.mode_flags[FLAG_LIMIT])
        begin
            if (sum > hi)
                clamped = hi;
            else if (sum < lo)
                clamped = lo;
        end
    end

    always_comb
    begin
        if (clamped > SUM_W'(32767))
            sat = 16'sh7FFF;
        else if (clamped < -SUM_W'(32768))
            sat = -16'sh8000;
        else
            sat = clamped[15:0];
    end

    assign new_weight = ctl.apply ? sat : weight;
    assign updated    = ctl.apply;

endmodule

// File: src/stdp_weight_update.sv
`timescale 1ns / 1ps
// stdp_weight_update: top level of the stdp synaptic weight update block
// depends on stdp_pkg, stdp_region and stdp_scale
//
// usage
//   input channel (in_valid / in_stall) carries one synapse update per transaction:
//   cmd, time_diff, modulator, weight, rand_bits, gate_pass
//   output channel (out_valid / out_stall) returns new_weight and updated,
//   exactly one result transaction per input transaction, in order
//   configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
//   only while no transaction is in flight
//   a transaction passes through the input register, then the result register,
//   before it is presented on the output; throughput: one transaction per cycle
//   unless the receiver stalls; all window, scaling, rounding and clamp logic
//   sits in one combinational stage between the two registers
//   when the receiver stalls, the result register holds and the input register
//   keeps accepting until it is full, then in_stall rises
//   reset clears both pipeline valid bits and sets every configuration register
//   to zero except weight_bits, which comes up as 8

module stdp_weight_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stdp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [stdp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic signed [15:0]                time_diff,
    input  logic signed [15:0]                modulator,
    input  logic signed [15:0]                weight,
    input  logic [15:0]                       rand_bits,
    input  logic                              gate_pass,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                new_weight,
    output logic                              updated
);
    import stdp_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               cmd_reg;
    logic signed [15:0] time_diff_reg;
    logic signed [15:0] modulator_reg;
    logic signed [15:0] weight_reg;
    logic [15:0]        rand_bits_reg;
    logic               gate_pass_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] new_weight_reg;
    logic               updated_reg;

    logic               res_ready;
    logic               in_take;
    scale_ctl_t         ctl;
    logic signed [15:0] new_weight_c;
    logic               updated_c;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAUSAL_EDGES:    cfg_next.causal_edges    = cfg_data[EDGE_W-1:0];
                CFG_ACAUSAL_EDGES:   cfg_next.acausal_edges   = cfg_data[EDGE_W-1:0];
                CFG_WINDOW_LENGTH:   cfg_next.window_length   = cfg_data[DATA_W-1:0];
                CFG_CAUSAL_REGIONS:  cfg_next.causal_regions  = cfg_data[BANK_W-1:0];
                CFG_ACAUSAL_REGIONS: cfg_next.acausal_regions = cfg_data[BANK_W-1:0];
                CFG_MODE_FLAGS:      cfg_next.mode_flags      = cfg_data[FLAG_W-1:0];
                CFG_ROUNDING_BITS:   cfg_next.rounding_bits   = cfg_data[CTRL_W-1:0];
                CFG_WEIGHT_BITS:     cfg_next.weight_bits     = cfg_data[CTRL_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.causal_edges    <= '0;
            cfg_reg.acausal_edges   <= '0;
            cfg_reg.window_length   <= '0;
            cfg_reg.causal_regions  <= '0;
            cfg_reg.acausal_regions <= '0;
            cfg_reg.mode_flags      <= '0;
            cfg_reg.rounding_bits   <= '0;
            cfg_reg.weight_bits     <= WEIGHT_BITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline handshake
    assign res_ready = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !res_ready;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (!in_stall)
            in_valid_next = in_valid;
        if (res_ready)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg       <= cmd;
            time_diff_reg <= time_diff;
            modulator_reg <= modulator;
            weight_reg    <= weight;
            rand_bits_reg <= rand_bits;
            gate_pass_reg <= gate_pass;
        end
        if (res_ready && in_valid_reg)
        begin
            new_weight_reg <= new_weight_c;
            updated_reg    <= updated_c;
        end
    end

    stdp_region u_region (
        .cfg       (cfg_reg),
        .cmd       (cmd_reg),
        .time_diff (time_diff_reg),
        .gate_pass (gate_pass_reg),
        .ctl       (ctl)
    );

    stdp_scale u_scale (
        .cfg        (cfg_reg),
        .ctl        (ctl),
        .modulator  (modulator_reg),
        .weight     (weight_reg),
        .rand_bits  (rand_bits_reg),
        .new_weight (new_weight_c),
        .updated    (updated_c)
    );

    assign out_valid  = out_valid_reg;
    assign new_weight = new_weight_reg;
    assign updated    = updated_reg;

endmodule

// File: tb/stdp_weight_update_test.sv
`timescale 1ns / 1ps
// stdp_weight_update_test: self-checking testbench for the stdp weight update block
// predicts every synapse update result in a scoreboard class and compares it field by field
// depends on stdp_pkg and stdp_weight_update

module stdp_weight_update_test;
    import stdp_pkg::*;

    localparam logic CMD_CAUSAL     = 1'b0;
    localparam logic CMD_ACAUSAL    = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   SETTLE_CYCLES  = 4;
    localparam int   REPORT_LIMIT   = 10;

    typedef struct {
        logic               cmd;
        logic signed [15:0] dt;
        logic signed [15:0] mod;
        logic signed [15:0] w;
        logic [15:0]        rnd;
        logic               gate;
    } syn_item_t;

    typedef struct {
        logic signed [15:0] nw;
        logic               upd;
    } syn_result_t;

    class weight_scoreboard;
        cfg_t        regs;
        syn_result_t weight_q[$];
        int          errors;
        int          results;
        int          applied;

        function new();
            regs = '0;
            regs.weight_bits = WEIGHT_BITS_RESET;
            errors = 0;
            results = 0;
            applied = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CAUSAL_EDGES:    regs.causal_edges    = val[EDGE_W-1:0];
                CFG_ACAUSAL_EDGES:   regs.acausal_edges   = val[EDGE_W-1:0];
                CFG_WINDOW_LENGTH:   regs.window_length   = val[DATA_W-1:0];
                CFG_CAUSAL_REGIONS:  regs.causal_regions  = val[BANK_W-1:0];
                CFG_ACAUSAL_REGIONS: regs.acausal_regions = val[BANK_W-1:0];
                CFG_MODE_FLAGS:      regs.mode_flags      = val[FLAG_W-1:0];
                CFG_ROUNDING_BITS:   regs.rounding_bits   = val[CTRL_W-1:0];
                CFG_WEIGHT_BITS:     regs.weight_bits     = val[CTRL_W-1:0];
                default: ;
            endcase
        endfunction

        // first matching window region, 0 when dt falls outside every region
        function bit pick_entry(longint dt, output logic [REGION_W-1:0] ent);
            longint c0, c1, a0, a1, len;
            c0  = longint'(regs.causal_edges[15:0]);
            c1  = longint'(regs.causal_edges[31:16]);
            a0  = longint'($signed(regs.acausal_edges[15:0]));
            a1  = longint'($signed(regs.acausal_edges[31:16]));
            len = longint'(regs.window_length);
            ent = '0;
            pick_entry = 1'b1;
            if (dt > 0 && dt < c0)
                ent = regs.causal_regions[11:0];
            else if (dt >= c0 && dt < c1)
                ent = regs.causal_regions[23:12];
            else if (dt >= c1 && dt < len)
                ent = regs.causal_regions[35:24];
            else if (dt < 0 && dt > a0)
                ent = regs.acausal_regions[11:0];
            else if (dt <= a0 && dt > a1)
                ent = regs.acausal_regions[23:12];
            else if (dt <= a1 && dt > -len)
                ent = regs.acausal_regions[35:24];
            else
                pick_entry = 1'b0;
        endfunction

        // multiply by 2^a, truncating toward zero for negative a
        function longint pow2_scale(longint x, longint a);
            longint mag;
            if (a >= 0)
                return x * (longint'(1) << a);
            mag = (x < 0 ? -x : x) >> (-a);
            return (x < 0) ? -mag : mag;
        endfunction

        function syn_result_t predict(syn_item_t it);
            syn_result_t         r;
            logic [REGION_W-1:0] ent;
            longint              dt, w, delta, e, sgn, mask, low, hi, lo;
            int                  decay, s, b;
            bit                  apply;
            dt = longint'(it.dt);
            w  = longint'(it.w);
            delta = 0;
            apply = regs.mode_flags[FLAG_PLASTIC] && it.gate &&
                    (it.cmd == CMD_ACAUSAL || (regs.mode_flags[FLAG_STDP] && dt > 0));
            if (apply)
            begin
                if (regs.mode_flags[FLAG_STDP])
                begin
                    if (pick_entry(dt, ent))
                    begin
                        e = longint'($signed(ent[4:0]));
                        decay = int'(ent[11:7]);
                        case (sign_code_t'(ent[6:5]))
                            SIGN_PLUS:  sgn = 1;
                            SIGN_MINUS: sgn = -1;
                            default:    sgn = 0;
                        endcase
                    end
                    else
                    begin
                        e = longint'(NO_REGION_EXP);
                        decay = 0;
                        sgn = 0;
                    end
                    if (regs.mode_flags[FLAG_EXPO])
                    begin
                        e = e - (dt >>> decay);
                        if (e > 31) e = 31;
                        if (e < -31) e = -31;
                    end
                    delta = sgn * pow2_scale(longint'(it.mod), e);
                end
                else
                begin
                    delta = pow2_scale(longint'(it.mod),
                                       longint'($signed(regs.acausal_regions[4:0])));
                end
                if (regs.mode_flags[FLAG_RROUND])
                begin
                    s = int'(regs.rounding_bits);
                    mask = (longint'(1) << s) - 1;
                    low = delta & mask;
                    delta = (delta >>> s) + (((longint'(it.rnd) & mask) < low) ? 1 : 0);
                end
                w = w + delta;
                if (regs.mode_flags[FLAG_LIMIT])
                begin
                    b = int'(regs.weight_bits);
                    if (b < 1) b = 1;
                    if (b > 16) b = 16;
                    hi = (longint'(1) << (b - 1)) - 1;
                    lo = -(longint'(1) << (b - 1));
                    if (w > hi) w = hi;
                    if (w < lo) w = lo;
                end
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
            end
            r.nw  = w[15:0];
            r.upd = apply;
            return r;
        endfunction

        function void note_input(syn_item_t it);
            weight_q.push_back(predict(it));
        endfunction

        function void check_result(logic signed [15:0] nw, logic upd);
            syn_result_t want;
            results++;
            if (upd === 1'b1)
                applied++;
            if (weight_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result transaction: new_weight %0d updated %0b",
                             nw, upd);
                return;
            end
            want = weight_q.pop_front();
            if (want.nw !== nw || want.upd !== upd)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"mismatch at result %0d: new_weight exp %0d got %0d, ",
                              "updated exp %0b got %0b"},
                             results, want.nw, nw, want.upd, upd);
            end
        endfunction

        function int pending();
            return weight_q.size();
        endfunction

        function void close_out();
            if (weight_q.size() != 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0d expected results never arrived", weight_q.size());
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    cmd = 1'b0;
    logic signed [15:0]      time_diff = '0;
    logic signed [15:0]      modulator = '0;
    logic signed [15:0]      weight = '0;
    logic [15:0]             rand_bits = '0;
    logic                    gate_pass = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [15:0]      new_weight;
    logic                    updated;

    weight_scoreboard sb;
    bit  no_idle = 1'b0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  settings = 0;

    stdp_weight_update u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .time_diff  (time_diff),
        .modulator  (modulator),
        .weight     (weight),
        .rand_bits  (rand_bits),
        .gate_pass  (gate_pass),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .new_weight (new_weight),
        .updated    (updated)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: check accepted transactions and toggle stall in random runs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(new_weight, updated);
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
            end
            else
            begin
                stall_left = idle_len();
                if (out_stall || stall_left == 0)
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(0, 6);
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_left = stall_left - 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic syn_item_t mk_item(logic c, int dt, int mod, int w, int rnd, logic g);
        syn_item_t it;
        it.cmd  = c;
        it.dt   = 16'(dt);
        it.mod  = 16'(mod);
        it.w    = 16'(w);
        it.rnd  = 16'(rnd);
        it.gate = g;
        return it;
    endfunction

    function automatic logic [REGION_W-1:0] mk_entry(int e, sign_code_t s, int decay);
        return {5'(decay), s, 5'(e)};
    endfunction

    function automatic syn_item_t random_item();
        syn_item_t it;
        int        len, pick, edge_v, r;
        len = int'(sb.regs.window_length);
        it.cmd  = 1'($urandom_range(0, 1));
        it.gate = ($urandom_range(0, 9) != 0);
        it.rnd  = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            it.dt = 16'($urandom);
        end
        else if (r < 7)
        begin
            // inside the window on the side that matches the command
            pick = $urandom_range(1, (len > 1) ? len : 1);
            it.dt = (it.cmd == CMD_CAUSAL) ? 16'(pick) : 16'(-pick);
        end
        else if (r < 9)
        begin
            case ($urandom_range(0, 5))
                0:       edge_v = int'(sb.regs.causal_edges[15:0]);
                1:       edge_v = int'(sb.regs.causal_edges[31:16]);
                2:       edge_v = int'($signed(sb.regs.acausal_edges[15:0]));
                3:       edge_v = int'($signed(sb.regs.acausal_edges[31:16]));
                4:       edge_v = len;
                default: edge_v = -len;
            endcase
            it.dt = 16'(edge_v + int'($urandom_range(0, 2)) - 1);
        end
        else
        begin
            pick = $urandom_range(0, 8);
            it.dt = (it.cmd == CMD_CAUSAL) ? 16'(-pick) : 16'(pick);
        end
        if ($urandom_range(0, 1))
            it.mod = 16'($urandom);
        else
            it.mod = 16'(int'($urandom_range(0, 1023)) - 512);
        if ($urandom_range(0, 1))
            it.w = 16'($urandom);
        else
            it.w = 16'(int'($urandom_range(0, 511)) - 256);
        return it;
    endfunction

    // caller sits at a rising edge; valid stays high into the next transaction
    task automatic send_item(syn_item_t it, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= it.cmd;
        time_diff <= it.dt;
        modulator <= it.mod;
        weight    <= it.w;
        rand_bits <= it.rnd;
        gate_pass <= it.gate;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(cfg_index_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_queued(inout syn_item_t q[$]);
        foreach (q[i])
            send_item(q[i], idle_len());
        q.delete();
        drain();
    endtask

    task automatic random_setting(int p, inout logic [CFG_DATA_W-1:0] vals [8]);
        int c0, c1, a0, a1, len;
        c0  = $urandom_range(1, 200);
        c1  = c0 + $urandom_range(0, 1500);
        len = c1 + $urandom_range(0, 3000);
        a0  = -int'($urandom_range(1, 200));
        a1  = a0 - int'($urandom_range(0, 1500));
        vals[CFG_CAUSAL_EDGES]    = CFG_DATA_W'({16'(c1), 16'(c0)});
        vals[CFG_ACAUSAL_EDGES]   = CFG_DATA_W'({16'(a1), 16'(a0)});
        vals[CFG_WINDOW_LENGTH]   = CFG_DATA_W'(16'(len));
        vals[CFG_CAUSAL_REGIONS]  = {4'($urandom), 32'($urandom)};
        vals[CFG_ACAUSAL_REGIONS] = {4'($urandom), 32'($urandom)};
        if ($urandom_range(0, 3) == 0)
        begin
            vals[CFG_CAUSAL_EDGES]  = CFG_DATA_W'(32'($urandom));
            vals[CFG_ACAUSAL_EDGES] = CFG_DATA_W'(32'($urandom));
        end
        if (p == 5)
        begin
            vals[CFG_CAUSAL_EDGES]    = CFG_DATA_W'({EDGE_W{1'b1}});
            vals[CFG_ACAUSAL_EDGES]   = CFG_DATA_W'({EDGE_W{1'b1}});
            vals[CFG_WINDOW_LENGTH]   = CFG_DATA_W'({DATA_W{1'b1}});
            vals[CFG_CAUSAL_REGIONS]  = {BANK_W{1'b1}};
            vals[CFG_ACAUSAL_REGIONS] = {BANK_W{1'b1}};
        end
        else if (p == 6)
        begin
            vals[CFG_CAUSAL_EDGES]    = '0;
            vals[CFG_ACAUSAL_EDGES]   = '0;
            vals[CFG_WINDOW_LENGTH]   = '0;
            vals[CFG_CAUSAL_REGIONS]  = '0;
            vals[CFG_ACAUSAL_REGIONS] = '0;
        end
        case (p)
            0:       vals[CFG_MODE_FLAGS] = CFG_DATA_W'((1 << FLAG_PLASTIC) |
                                                        (1 << FLAG_STDP));
            1, 5:    vals[CFG_MODE_FLAGS] = CFG_DATA_W'({FLAG_W{1'b1}});
            2:       vals[CFG_MODE_FLAGS] = '0;
            3:       vals[CFG_MODE_FLAGS] = CFG_DATA_W'(1 << FLAG_PLASTIC);
            4:       vals[CFG_MODE_FLAGS] = CFG_DATA_W'((1 << FLAG_PLASTIC) |
                                                        (1 << FLAG_STDP) |
                                                        (1 << FLAG_EXPO));
            default: vals[CFG_MODE_FLAGS] = CFG_DATA_W'($urandom_range(0, 31) |
                                                        (1 << FLAG_PLASTIC));
        endcase
        case (p)
            1:       vals[CFG_ROUNDING_BITS] = '0;
            5:       vals[CFG_ROUNDING_BITS] = CFG_DATA_W'({CTRL_W{1'b1}});
            7:       vals[CFG_ROUNDING_BITS] = CFG_DATA_W'(16);
            default: vals[CFG_ROUNDING_BITS] = CFG_DATA_W'($urandom_range(0, 20));
        endcase
        case (p)
            1:       vals[CFG_WEIGHT_BITS] = CFG_DATA_W'(1);
            5:       vals[CFG_WEIGHT_BITS] = CFG_DATA_W'({CTRL_W{1'b1}});
            6:       vals[CFG_WEIGHT_BITS] = '0;
            7:       vals[CFG_WEIGHT_BITS] = CFG_DATA_W'(16);
            default: vals[CFG_WEIGHT_BITS] = CFG_DATA_W'($urandom_range(2, 16));
        endcase
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] vals [8];
        syn_item_t             dir_q[$];
        int                    n_items;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: known window with three regions per side
        vals[CFG_CAUSAL_EDGES]    = CFG_DATA_W'({16'd100, 16'd10});
        vals[CFG_ACAUSAL_EDGES]   = CFG_DATA_W'({16'(-100), 16'(-10)});
        vals[CFG_WINDOW_LENGTH]   = CFG_DATA_W'(16'd1000);
        vals[CFG_CAUSAL_REGIONS]  = {mk_entry(-15, SIGN_PLUS, 0), mk_entry(0, SIGN_MINUS, 5),
                                     mk_entry(2, SIGN_PLUS, 3)};
        vals[CFG_ACAUSAL_REGIONS] = {mk_entry(15, SIGN_MINUS, 31), mk_entry(-3, SIGN_NONE, 1),
                                     mk_entry(1, SIGN_MINUS, 2)};
        vals[CFG_MODE_FLAGS]      = CFG_DATA_W'((1 << FLAG_PLASTIC) | (1 << FLAG_STDP) |
                                                (1 << FLAG_LIMIT));
        vals[CFG_ROUNDING_BITS]   = CFG_DATA_W'(4);
        vals[CFG_WEIGHT_BITS]     = CFG_DATA_W'(8);
        program_regs(vals);

        // causal with dt zero or negative leaves the weight alone, as does a closed gate
        dir_q.push_back(mk_item(CMD_CAUSAL, 0, 100, 5, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, -5, 100, 5, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 5, 100, 5, 0, 1'b0));
        dir_q.push_back(mk_item(CMD_CAUSAL, 1, 32767, 0, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 9, -32768, 0, 16'hffff, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 10, 1000, 20, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 99, -1000, -20, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 100, 7, 3, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 999, 32767, -100, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 1000, 32767, 17, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 32767, 32767, 32767, 16'hffff, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -1, 50, -128, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -10, 50, 40, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -100, 1, 0, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -999, -3, 0, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -1000, 500, 9, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -32768, -32768, -32768, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, 0, 200, 1, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, 500, 200, 1, 0, 1'b1));
        send_queued(dir_q);

        // exponential decay with randomized rounding, no clamp
        vals[CFG_MODE_FLAGS] = CFG_DATA_W'((1 << FLAG_PLASTIC) | (1 << FLAG_STDP) |
                                           (1 << FLAG_EXPO) | (1 << FLAG_RROUND));
        program_regs(vals);
        dir_q.push_back(mk_item(CMD_CAUSAL, 3, 1000, 0, 16'h000f, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 50, -777, 100, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 700, 12345, -5, 16'h0003, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -7, -3, 0, 16'hffff, 1'b1));
        dir_q.push_back(mk_item(CMD_ACAUSAL, -500, 32767, 32767, 0, 1'b1));
        send_queued(dir_q);

        // stdp off: acausal uses the first acausal exponent, causal does nothing
        vals[CFG_MODE_FLAGS] = CFG_DATA_W'(1 << FLAG_PLASTIC);
        program_regs(vals);
        dir_q.push_back(mk_item(CMD_ACAUSAL, -3, 400, 10, 0, 1'b1));
        dir_q.push_back(mk_item(CMD_CAUSAL, 5, 400, 10, 0, 1'b1));
        send_queued(dir_q);

        // random part, one register setting per phase
        for (int p = 0; p < 11; p++)
        begin
            random_setting(p, vals);
            program_regs(vals);
            no_idle = (p == 4 || p == 8);
            n_items = (p == 2) ? 20 : 110;
            for (int i = 0; i < n_items; i++)
            begin
                if (p == 6 && i == n_items / 2)
                begin
                    // hold off until the pipeline is empty, then resume
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.pending() != 0);
                end
                send_item(random_item(), idle_len());
            end
            drain();
        end

        sb.close_out();
        $display("checked %0d weight results (%0d applied updates) over %0d register settings",
                 sb.results, sb.applied, settings);
        $display("mismatches and missing or extra results: %0d", sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: stdp_weight_update.f
src/stdp_pkg.sv
src/stdp_region.sv
src/stdp_scale.sv
src/stdp_weight_update.sv
tb/stdp_weight_update_test.sv
